// File: hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants shared by the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_SLEEP  = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_CREATE = 3'd4,
    CMD_KILL   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_READY = 2'd1,
    ST_RUN   = 2'd2,
    ST_SLEEP = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_NO_RUN   = 2'd3
  } status_e;

  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 8;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] sleep_ticks;
    logic [15:0] target_id;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic [15:0] running_id;
    logic [15:0] created_id;
  } rsp_word_t;

endpackage

// File: hdl/rrts_stream_if.sv
// ----------------------------------------------------------------------------
// rrts_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface rrts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task table with round-robin scheduling, quantum preemption and sleep.
// ----------------------------------------------------------------------------
// Usage: commands arrive as words on cmd (tick, yield, sleep, exit, create,
// kill); each command yields exactly one response word on rsp. Registers
// sched_enable (index 0) and quantum_ticks (index 1) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while
// the block is idle, as the block itself does not enforce it.
// The longest command is a tick with a reschedule: a single slot-compare
// unit visits the table one slot per cycle for the wake sweep and once
// more for the round-robin search. cmd is not ready while a command is
// being worked on; the response sits in an output register and the next
// command is taken while it waits, but its result waits until the
// previous response has been taken.
// Reset: all slots free, no running task, time zero, next id one,
// scheduler disabled, quantum ten.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rrts_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rrts_pkg::CfgDataW-1:0]  cfg_data_i,
  rrts_stream_if.sink                    cmd,
  rrts_stream_if.source                  rsp
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WAKE, S_CHARGE, S_SCAN, S_FIND, S_DONE
  } state_e;

  state_e state_q;
  logic   en_q;
  logic [7:0] quant_q;

  rrts_pkg::slot_state_e st_q [SLOTS];
  logic [15:0] id_q [SLOTS];
  logic [31:0] wake_q [SLOTS];
  logic [7:0]  left_q [SLOTS];
  logic [31:0] cpu_q [SLOTS];

  logic [SW-1:0] cur_q;
  logic          curv_q;
  logic [31:0]   time_q;
  logic [15:0]   nid_q;
  logic [CW-1:0] live_q;

  rrts_pkg::cmd_word_t c_q;
  logic [SW-1:0] idx_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    sts_q;
  logic [15:0]   crt_q;
  logic          rsp_v_q;
  rrts_pkg::rsp_word_t rsp_q;

  logic cur_run;
  logic [SW-1:0] nxt_idx;
  logic last;

  assign cur_run = curv_q && (st_q[cur_q] == rrts_pkg::ST_RUN);
  assign nxt_idx = (idx_q == SW'(SLOTS - 1)) ? '0 : idx_q + SW'(1);
  assign last = (cnt_q == CW'(SLOTS - 1));

  assign cmd.ready = (state_q == S_IDLE);
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q    <= 1'b0;
      quant_q <= 8'd10;
      for (int i = 0; i < SLOTS; i++) st_q[i] <= rrts_pkg::ST_FREE;
      cur_q   <= '0;
      curv_q  <= 1'b0;
      time_q  <= '0;
      nid_q   <= 16'd1;
      live_q  <= '0;
      idx_q   <= '0;
      cnt_q   <= '0;
      sts_q   <= '0;
      crt_q   <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rrts_pkg::CFG_ENABLE) en_q <= cfg_data_i[0];
        else if (cfg_idx_i == rrts_pkg::CFG_QUANTUM) quant_q <= cfg_data_i;
      end
      if (rsp.valid && rsp.ready && state_q != S_DONE) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd.valid) begin
            c_q   <= cmd.data;
            crt_q <= '0;
            idx_q <= '0;
            cnt_q <= '0;
            case (cmd.data.command)
              rrts_pkg::CMD_TICK: begin
                sts_q <= rrts_pkg::STS_OK;
                if (en_q) begin
                  time_q  <= time_q + 32'd1;
                  state_q <= S_WAKE;
                end else begin
                  state_q <= S_DONE;
                end
              end
              rrts_pkg::CMD_YIELD: begin
                sts_q   <= rrts_pkg::STS_OK;
                state_q <= S_CHARGE;
              end
              rrts_pkg::CMD_SLEEP, rrts_pkg::CMD_EXIT: begin
                if (cur_run) begin
                  if (cmd.data.command == rrts_pkg::CMD_SLEEP) begin
                    st_q[cur_q]   <= rrts_pkg::ST_SLEEP;
                    wake_q[cur_q] <= time_q + {16'd0, cmd.data.sleep_ticks};
                  end else begin
                    st_q[cur_q] <= rrts_pkg::ST_FREE;
                    if (live_q != '0) live_q <= live_q - CW'(1);
                  end
                  sts_q   <= rrts_pkg::STS_OK;
                  state_q <= S_CHARGE;
                end else begin
                  sts_q   <= rrts_pkg::STS_NO_RUN;
                  state_q <= S_DONE;
                end
              end
              rrts_pkg::CMD_CREATE: begin
                if (live_q < CW'(SLOTS)) begin
                  sts_q   <= rrts_pkg::STS_OK;
                  state_q <= S_FIND;
                end else begin
                  sts_q   <= rrts_pkg::STS_FULL;
                  state_q <= S_DONE;
                end
              end
              rrts_pkg::CMD_KILL: begin
                sts_q   <= rrts_pkg::STS_NOT_FOUND;
                state_q <= S_FIND;
              end
              default: begin
                sts_q   <= rrts_pkg::STS_OK;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_WAKE: begin
          if (st_q[idx_q] == rrts_pkg::ST_SLEEP && wake_q[idx_q] <= time_q)
            st_q[idx_q] <= rrts_pkg::ST_READY;
          idx_q <= nxt_idx;
          cnt_q <= cnt_q + CW'(1);
          if (last) state_q <= S_CHARGE;
        end
        S_CHARGE: begin
          if (c_q.command == rrts_pkg::CMD_TICK && cur_run) begin
            cpu_q[cur_q] <= cpu_q[cur_q] + 32'd1;
            if (left_q[cur_q] <= 8'd1) left_q[cur_q] <= quant_q;
            else left_q[cur_q] <= left_q[cur_q] - 8'd1;
          end
          if (!en_q || live_q == '0) state_q <= S_DONE;
          else if (c_q.command == rrts_pkg::CMD_TICK && cur_run && left_q[cur_q] > 8'd1)
            state_q <= S_DONE;
          else state_q <= S_SCAN;
          idx_q <= curv_q ? ((cur_q == SW'(SLOTS - 1)) ? '0 : cur_q + SW'(1)) : '0;
          cnt_q <= '0;
        end
        S_SCAN: begin
          if (st_q[idx_q] == rrts_pkg::ST_READY) begin
            if (cur_run && cur_q != idx_q) st_q[cur_q] <= rrts_pkg::ST_READY;
            st_q[idx_q] <= rrts_pkg::ST_RUN;
            cur_q   <= idx_q;
            curv_q  <= 1'b1;
            state_q <= S_DONE;
          end else begin
            idx_q <= nxt_idx;
            cnt_q <= cnt_q + CW'(1);
            if (last) state_q <= S_DONE;
          end
        end
        S_FIND: begin
          if (c_q.command == rrts_pkg::CMD_CREATE) begin
            if (st_q[idx_q] == rrts_pkg::ST_FREE) begin
              id_q[idx_q]   <= nid_q;
              crt_q         <= nid_q;
              nid_q         <= (nid_q == 16'hFFFF) ? 16'd1 : nid_q + 16'd1;
              st_q[idx_q]   <= rrts_pkg::ST_READY;
              left_q[idx_q] <= quant_q;
              cpu_q[idx_q]  <= '0;
              wake_q[idx_q] <= '0;
              live_q        <= live_q + CW'(1);
              state_q       <= S_DONE;
            end else if (last) begin
              sts_q   <= rrts_pkg::STS_FULL;
              state_q <= S_DONE;
            end
          end else begin
            if (st_q[idx_q] != rrts_pkg::ST_FREE && id_q[idx_q] == c_q.target_id) begin
              st_q[idx_q] <= rrts_pkg::ST_FREE;
              if (live_q != '0) live_q <= live_q - CW'(1);
              sts_q   <= rrts_pkg::STS_OK;
              state_q <= S_DONE;
            end else if (last) begin
              state_q <= S_DONE;
            end
          end
          idx_q <= nxt_idx;
          cnt_q <= cnt_q + CW'(1);
        end
        S_DONE: begin
          if (!rsp_v_q || rsp.ready) begin
            rsp_v_q <= 1'b1;
            rsp_q.status        <= sts_q;
            rsp_q.running_valid <= cur_run;
            rsp_q.running_slot  <= cur_run ? 4'(cur_q) : 4'd0;
            rsp_q.running_id    <= cur_run ? id_q[cur_q] : 16'd0;
            rsp_q.created_id    <= crt_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CW'(SLOTS)) else $error("live count above table size");
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !cmd.ready) else $error("ready while busy");
  a_rsp_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_v_q) |-> $past(state_q == S_DONE)) else $error("response out of order");
  a_nid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nid_q != 16'd0) else $error("next id is zero");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives scheduler commands through the valid/ready channels and checks each
// response word against a cycle-free task-table model or a fixed row word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 16;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned SETTLE = NSLOT + 8;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;
  typedef struct {
    row_kind_e                    kind;
    rrts_pkg::cmd_word_t          word;
    logic [rrts_pkg::CfgIdxW-1:0] idx;
    logic [7:0]                   val;
    bit                           typed;
    rrts_pkg::rsp_word_t          rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rrts_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rrts_pkg::CfgDataW-1:0] cfg_data_i = '0;

  rrts_stream_if #(.T(rrts_pkg::cmd_word_t)) cmd_if ();
  rrts_stream_if #(.T(rrts_pkg::rsp_word_t)) rsp_if ();

  round_robin_task_scheduler #(.SLOTS(NSLOT)) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cmd       (cmd_if.sink),
    .rsp       (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // scheduler model
  rrts_pkg::slot_state_e tsk_state[NSLOT];
  logic [15:0] tsk_id[NSLOT];
  logic [31:0] tsk_wake[NSLOT];
  logic [7:0]  tsk_left[NSLOT];
  logic [31:0] tsk_cpu[NSLOT];
  int unsigned cur_slot;
  bit          cur_valid;
  logic [31:0] now_ticks;
  logic [15:0] id_next;
  int unsigned live_tasks;
  bit          m_enable;
  logic [7:0]  m_quantum;

  rrts_pkg::rsp_word_t rsp_expected[$];
  bit                  pend_typed[$];
  rrts_pkg::rsp_word_t pend_rsp[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          cmd_fire = 1'b0;

  function automatic bit cur_running();
    return cur_valid && tsk_state[cur_slot] == rrts_pkg::ST_RUN;
  endfunction

  function automatic void pick_next();
    int unsigned first;
    int unsigned k;
    if (!m_enable || live_tasks == 0) return;
    first = cur_valid ? (cur_slot + 1) % NSLOT : 0;
    for (int i = 0; i < NSLOT; i++) begin
      k = (first + i) % NSLOT;
      if (tsk_state[k] == rrts_pkg::ST_READY) begin
        if (cur_running() && cur_slot != k) tsk_state[cur_slot] = rrts_pkg::ST_READY;
        cur_slot = k;
        cur_valid = 1'b1;
        tsk_state[k] = rrts_pkg::ST_RUN;
        return;
      end
    end
  endfunction

  function automatic rrts_pkg::rsp_word_t sched_step(rrts_pkg::cmd_word_t w);
    rrts_pkg::rsp_word_t r;
    r = '0;
    case (w.command)
      rrts_pkg::CMD_TICK: begin
        if (m_enable) begin
          now_ticks++;
          for (int i = 0; i < NSLOT; i++)
            if (tsk_state[i] == rrts_pkg::ST_SLEEP && tsk_wake[i] <= now_ticks)
              tsk_state[i] = rrts_pkg::ST_READY;
          if (cur_running()) begin
            tsk_cpu[cur_slot]++;
            if (tsk_left[cur_slot] <= 8'd1) begin
              tsk_left[cur_slot] = m_quantum;
              pick_next();
            end else begin
              tsk_left[cur_slot]--;
            end
          end else begin
            pick_next();
          end
        end
      end
      rrts_pkg::CMD_YIELD: pick_next();
      rrts_pkg::CMD_SLEEP: begin
        if (cur_running()) begin
          tsk_state[cur_slot] = rrts_pkg::ST_SLEEP;
          tsk_wake[cur_slot] = now_ticks + 32'(w.sleep_ticks);
          pick_next();
        end else begin
          r.status = rrts_pkg::STS_NO_RUN;
        end
      end
      rrts_pkg::CMD_EXIT: begin
        if (cur_running()) begin
          tsk_state[cur_slot] = rrts_pkg::ST_FREE;
          if (live_tasks > 0) live_tasks--;
          pick_next();
        end else begin
          r.status = rrts_pkg::STS_NO_RUN;
        end
      end
      rrts_pkg::CMD_CREATE: begin
        r.status = rrts_pkg::STS_FULL;
        for (int i = 0; i < NSLOT; i++) begin
          if (live_tasks < NSLOT && tsk_state[i] == rrts_pkg::ST_FREE) begin
            tsk_id[i] = id_next;
            r.created_id = id_next;
            id_next++;
            if (id_next == 16'd0) id_next = 16'd1;
            tsk_state[i] = rrts_pkg::ST_READY;
            tsk_left[i] = m_quantum;
            tsk_cpu[i] = '0;
            tsk_wake[i] = '0;
            live_tasks++;
            r.status = rrts_pkg::STS_OK;
            break;
          end
        end
      end
      rrts_pkg::CMD_KILL: begin
        r.status = rrts_pkg::STS_NOT_FOUND;
        for (int i = 0; i < NSLOT; i++) begin
          if (tsk_state[i] != rrts_pkg::ST_FREE && tsk_id[i] == w.target_id) begin
            tsk_state[i] = rrts_pkg::ST_FREE;
            if (live_tasks > 0) live_tasks--;
            r.status = rrts_pkg::STS_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    if (cur_running()) begin
      r.running_valid = 1'b1;
      r.running_slot = 4'(cur_slot);
      r.running_id = tsk_id[cur_slot];
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    rrts_pkg::rsp_word_t got;
    rrts_pkg::rsp_word_t want;
    rrts_pkg::rsp_word_t pred;
    bit any;
    any = 1'b0;
    cmd_fire = cmd_if.valid && cmd_if.ready;
    if (cmd_fire) begin
      any = 1'b1;
      pred = sched_step(cmd_if.data);
      if (pend_typed.pop_front()) pred = pend_rsp.pop_front();
      else void'(pend_rsp.pop_front());
      rsp_expected.push_back(pred);
    end
    if (rsp_if.valid && rsp_if.ready) begin
      any = 1'b1;
      got = rsp_if.data;
      if (rsp_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response word %h", got);
      end else begin
        want = rsp_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sts=%0d v=%0d slot=%0d id=%0d new=%0d,",
                     want.status, want.running_valid, want.running_slot,
                     want.running_id, want.created_id,
                     " got sts=%0d v=%0d slot=%0d id=%0d new=%0d",
                     got.status, got.running_valid, got.running_slot,
                     got.running_id, got.created_id);
        end
      end
    end
    quiet_cycles = any ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(rrts_pkg::cmd_word_t w, bit typed, rrts_pkg::rsp_word_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pend_typed.push_back(typed);
    pend_rsp.push_back(r);
    cmd_if.valid <= 1'b1;
    cmd_if.data <= w;
    do @(negedge clk_i); while (!cmd_fire);
  endtask

  task automatic write_reg(logic [rrts_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
    cmd_if.valid <= 1'b0;
    @(negedge clk_i);
    while (rsp_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= rrts_pkg::CfgDataW'(val);
    if (idx == rrts_pkg::CFG_ENABLE) m_enable = val[0];
    else m_quantum = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic rrts_pkg::cmd_word_t mk(rrts_pkg::cmd_e c, logic [15:0] s,
                                             logic [15:0] t);
    rrts_pkg::cmd_word_t w;
    w.command = c;
    w.sleep_ticks = s;
    w.target_id = t;
    return w;
  endfunction

  function automatic rrts_pkg::cmd_word_t rand_word();
    rrts_pkg::cmd_word_t w;
    int unsigned r;
    int unsigned k;
    w.sleep_ticks = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30));
    w.target_id = 16'($urandom);
    r = $urandom_range(99);
    if (r < 30) w.command = rrts_pkg::CMD_TICK;
    else if (r < 40) w.command = rrts_pkg::CMD_YIELD;
    else if (r < 52) w.command = rrts_pkg::CMD_SLEEP;
    else if (r < 62) w.command = rrts_pkg::CMD_EXIT;
    else if (r < 80) w.command = rrts_pkg::CMD_CREATE;
    else if (r < 95) begin
      w.command = rrts_pkg::CMD_KILL;
      k = $urandom_range(NSLOT - 1);
      if ($urandom_range(9) < 7 && tsk_state[k] != rrts_pkg::ST_FREE) w.target_id = tsk_id[k];
    end else begin
      w.command = rrts_pkg::cmd_e'(3'($urandom_range(7, 6)));
    end
    return w;
  endfunction

  initial begin
    row_t rows[$];
    row_t row;
    rrts_pkg::rsp_word_t none_run;
    rrts_pkg::rsp_word_t first_new;
    int unsigned q_pick;

    for (int i = 0; i < NSLOT; i++) begin
      tsk_state[i] = rrts_pkg::ST_FREE;
      tsk_id[i] = '0;
      tsk_wake[i] = '0;
      tsk_left[i] = '0;
      tsk_cpu[i] = '0;
    end
    cur_slot = 0;
    cur_valid = 1'b0;
    now_ticks = '0;
    id_next = 16'd1;
    live_tasks = 0;
    m_enable = 1'b0;
    m_quantum = 8'd10;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;

    none_run = '0;
    none_run.status = rrts_pkg::STS_NO_RUN;
    first_new = '0;
    first_new.created_id = 16'd1;

    row = '{ROW_CMD, mk(rrts_pkg::CMD_EXIT, 16'h0, 16'h0), rrts_pkg::CFG_ENABLE, 8'd0,
            1'b1, none_run};
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_SLEEP, 16'hFFFF, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_KILL, 16'h0, 16'hFFFF);
    row.rsp = '0;
    row.rsp.status = rrts_pkg::STS_NOT_FOUND;
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_CREATE, 16'h0, 16'h0);
    row.rsp = first_new;
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_TICK, 16'h0, 16'h0);
    row.rsp = '0;
    rows.push_back(row);
    row = '{ROW_CFG, '0, rrts_pkg::CFG_ENABLE, 8'd1, 1'b0, '0};
    rows.push_back(row);
    row.idx = rrts_pkg::CFG_QUANTUM;
    row.val = 8'd1;
    rows.push_back(row);
    row = '{ROW_CMD, mk(rrts_pkg::CMD_TICK, 16'h0, 16'h0), rrts_pkg::CFG_ENABLE, 8'd0,
            1'b0, '0};
    rows.push_back(row);
    for (int i = 0; i < NSLOT; i++) begin
      row.word = mk(rrts_pkg::CMD_CREATE, 16'h0, 16'h0);
      rows.push_back(row);
    end
    row.word = mk(rrts_pkg::CMD_YIELD, 16'h0, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::cmd_e'(3'd6), 16'hFFFF, 16'hFFFF);
    rows.push_back(row);
    row.word = mk(rrts_pkg::cmd_e'(3'd7), 16'h0, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_SLEEP, 16'hFFFF, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_SLEEP, 16'h0, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_TICK, 16'h0, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_EXIT, 16'h0, 16'h0);
    rows.push_back(row);
    row.word = mk(rrts_pkg::CMD_KILL, 16'h0, 16'd2);
    rows.push_back(row);
    row = '{ROW_CFG, '0, rrts_pkg::CFG_QUANTUM, 8'd0, 1'b0, '0};
    rows.push_back(row);
    row = '{ROW_CMD, mk(rrts_pkg::CMD_TICK, 16'h0, 16'h0), rrts_pkg::CFG_ENABLE, 8'd0,
            1'b0, '0};
    rows.push_back(row);
    rows.push_back(row);
    row = '{ROW_CFG, '0, rrts_pkg::CFG_QUANTUM, 8'd255, 1'b0, '0};
    rows.push_back(row);
    row = '{ROW_CMD, mk(rrts_pkg::CMD_TICK, 16'h0, 16'h0), rrts_pkg::CFG_ENABLE, 8'd0,
            1'b0, '0};
    rows.push_back(row);

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].val);
      else send_word(rows[i].word, rows[i].typed, rows[i].rsp);
    end

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 31 : 0;
      q_pick = $urandom_range(3);
      write_reg(rrts_pkg::CFG_QUANTUM,
                (ph == 3) ? 8'd1 : (q_pick == 0) ? 8'd255 : 8'($urandom_range(6, 2)));
      write_reg(rrts_pkg::CFG_ENABLE, (ph == 2) ? 8'd0 : 8'd1);
      repeat ((ph == 2) ? 80 : 240) send_word(rand_word(), 1'b0, '0);
    end

    cmd_if.valid <= 1'b0;
    while (rsp_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE * 2) @(negedge clk_i);
    if (mismatches == 0 && rsp_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
